FILE: hw/rtl/xtbd_pkg.sv
package xtbd_pkg;

  typedef logic [31:0] word_t;

  // The four key words, indexed by the two sum bits that pick one of them.
  typedef word_t [3:0] key_set_t;

  // One block as it travels down the round pipeline.
  typedef struct packed {
    logic  valid;
    word_t v0;
    word_t v1;
  } blk_t;

  localparam word_t XTEA_DELTA = 32'h9E37_79B9;

  localparam int unsigned KEY_IDX_W = 2;

  localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

  localparam word_t KEY_RST_0 = 32'h4776_3879;
  localparam word_t KEY_RST_1 = 32'h3376_7545;
  localparam word_t KEY_RST_2 = 32'h6670_6F58;
  localparam word_t KEY_RST_3 = 32'h6544_3372;

  function automatic word_t mix_word(input word_t w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

FILE: hw/rtl/xtbd_half_round.sv
module xtbd_half_round #(
  parameter logic [31:0] SUM    = 32'h0,
  parameter bit          SECOND = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  xtbd_pkg::key_set_t key,
  input  xtbd_pkg::blk_t    blk_in,
  output xtbd_pkg::blk_t    blk_out
);
  import xtbd_pkg::*;

  // The first half-round picks its key word with sum bits 12..11, the second with bits 1..0.
  localparam logic [KEY_IDX_W-1:0] KEY_SEL = SECOND ? SUM[1:0] : SUM[12:11];

  logic  valid_r, valid_nxt;
  word_t v0_r, v0_nxt;
  word_t v1_r, v1_nxt;
  word_t src;
  word_t tweak;

  always_comb begin
    src   = SECOND ? blk_in.v1 : blk_in.v0;
    tweak = mix_word(src) ^ (SUM + key[KEY_SEL]);
    valid_nxt = blk_in.valid;
    v0_nxt    = SECOND ? blk_in.v0 - tweak : blk_in.v0;
    v1_nxt    = SECOND ? blk_in.v1 : blk_in.v1 - tweak;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  assign blk_out = '{valid: valid_r, v0: v0_r, v1: v1_r};

endmodule

FILE: hw/rtl/xtbd_out_skid.sv
module xtbd_out_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  xtbd_pkg::blk_t blk_in,
  output logic           pipe_en,
  output logic           out_valid,
  input  logic           out_stall,
  output xtbd_pkg::word_t out_v0,
  output xtbd_pkg::word_t out_v1
);
  import xtbd_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  word_t out_v0_r, out_v0_nxt;
  word_t out_v1_r, out_v1_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  word_t skid_v0_r, skid_v0_nxt;
  word_t skid_v1_r, skid_v1_nxt;
  logic  take;
  logic  drain;

  assign pipe_en = !skid_valid_r;
  assign take    = blk_in.valid && !skid_valid_r;
  assign drain   = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_v0_nxt     = out_v0_r;
    out_v1_nxt     = out_v1_r;
    skid_valid_nxt = skid_valid_r;
    skid_v0_nxt    = skid_v0_r;
    skid_v1_nxt    = skid_v1_r;
    if (drain) begin
      out_valid_nxt  = skid_valid_r || take;
      out_v0_nxt     = skid_valid_r ? skid_v0_r : blk_in.v0;
      out_v1_nxt     = skid_valid_r ? skid_v1_r : blk_in.v1;
      skid_valid_nxt = 1'b0;
    end else if (take) begin
      skid_valid_nxt = 1'b1;
      skid_v0_nxt    = blk_in.v0;
      skid_v1_nxt    = blk_in.v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_v0_r  <= out_v0_nxt;
    out_v1_r  <= out_v1_nxt;
    skid_v0_r <= skid_v0_nxt;
    skid_v1_r <= skid_v1_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_v0    = out_v0_r;
  assign out_v1    = out_v1_r;

endmodule

FILE: hw/rtl/xtea_block_decrypt.sv
// XTEA block decryption, fully pipelined. Each beat on the input carries one 64-bit
// ciphertext block as two little-endian 32-bit words, and each beat on the output carries
// the matching plaintext block, in the same order. The 32 (ROUND_PAIRS) XTEA round pairs are
// unrolled into 2*ROUND_PAIRS register stages, one Feistel half-round per stage, followed
// by an output register with a one-entry skid buffer. A new block may enter on every
// clock unless in_stall is high, so throughput is one block per cycle while the output
// is not stalled. The running sum of each stage is a constant worked out at
// elaboration, so the only datapath in a stage is the shift-xor-add mix, one key add,
// an xor and one subtract. The 128-bit key sits in four 32-bit registers that reset
// to the built-in key and are written through the cfg port; change the key only while
// no block is in flight.
module xtea_block_decrypt #(
  parameter int unsigned ROUND_PAIRS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  xtbd_pkg::word_t     cfg_wdata,
  // Ciphertext input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  xtbd_pkg::word_t     in_cipher_first,
  input  xtbd_pkg::word_t     in_cipher_second,
  // Plaintext output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output xtbd_pkg::word_t     out_plain_first,
  output xtbd_pkg::word_t     out_plain_second
);
  import xtbd_pkg::*;

  localparam int unsigned STAGES = 2 * ROUND_PAIRS;

  key_set_t key_r, key_nxt;
  blk_t     stage_blk [STAGES+1];
  logic     pipe_en;

  // Key registers. An index selects one of the four words.
  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      case (cfg_index)
        KEY_IDX_0: key_nxt[0] = cfg_wdata;
        KEY_IDX_1: key_nxt[1] = cfg_wdata;
        KEY_IDX_2: key_nxt[2] = cfg_wdata;
        KEY_IDX_3: key_nxt[3] = cfg_wdata;
        default:   key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= {KEY_RST_3, KEY_RST_2, KEY_RST_1, KEY_RST_0};
    end else begin
      key_r <= key_nxt;
    end
  end

  // The whole round pipeline moves together; it only halts while the skid buffer is full,
  // and then the input is stalled too, so nothing is dropped or taken twice.
  assign in_stall = !pipe_en;

  assign stage_blk[0] = '{valid: in_valid, v0: in_cipher_first, v1: in_cipher_second};

  // Pair r uses sum = (ROUND_PAIRS - r) * delta for its first half-round and the same
  // value less one delta for its second, all modulo 2^32.
  for (genvar r = 0; r < ROUND_PAIRS; r++) begin : g_pair
    localparam logic [63:0] PROD_A = 64'(ROUND_PAIRS - r) * 64'(XTEA_DELTA);
    localparam logic [63:0] PROD_B = 64'(ROUND_PAIRS - r - 1) * 64'(XTEA_DELTA);

    xtbd_half_round #(
      .SUM    (PROD_A[31:0]),
      .SECOND (1'b0)
    ) u_first (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .key     (key_r),
      .blk_in  (stage_blk[2*r]),
      .blk_out (stage_blk[2*r+1])
    );

    xtbd_half_round #(
      .SUM    (PROD_B[31:0]),
      .SECOND (1'b1)
    ) u_second (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .key     (key_r),
      .blk_in  (stage_blk[2*r+1]),
      .blk_out (stage_blk[2*r+2])
    );
  end

  // The output register and skid entry decouple out_stall from the pipeline enable.
  xtbd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_in    (stage_blk[STAGES]),
    .pipe_en   (pipe_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_v0    (out_plain_first),
    .out_v1    (out_plain_second)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xtbd_pkg::*;

  localparam int unsigned ROUND_PAIRS = 32;
  // The pipeline holds one half-round per stage plus the output register.
  localparam int unsigned PIPE_DEPTH = 2 * ROUND_PAIRS + 1;
  // Register indexes in the order the key words are written.
  localparam logic [KEY_IDX_W-1:0] KEY_ORDER [4] = '{KEY_IDX_0, KEY_IDX_1, KEY_IDX_2, KEY_IDX_3};

  typedef struct packed {
    word_t first;
    word_t second;
  } plain_blk_t;

  // Tracks the key that the block holds and the plaintext blocks that are owed on the
  // output, oldest first. Every accepted ciphertext beat owes exactly one plaintext beat.
  class xtea_plain_tracker;
    key_set_t   key;
    plain_blk_t plain_due[$];
    int         failures;

    function new();
      key[0]   = KEY_RST_0;
      key[1]   = KEY_RST_1;
      key[2]   = KEY_RST_2;
      key[3]   = KEY_RST_3;
      failures = 0;
    endfunction

    function void set_key(logic [KEY_IDX_W-1:0] idx, word_t value);
      key[idx] = value;
    endfunction

    function word_t feistel_mix(word_t w);
      return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // Runs the full decryption and queues the plaintext the block must return.
    function void note_cipher(word_t c0, word_t c1);
      word_t v0    = c0;
      word_t v1    = c1;
      word_t total = word_t'(ROUND_PAIRS * XTEA_DELTA);
      for (int r = 0; r < ROUND_PAIRS; r++) begin
        v1    = v1 - (feistel_mix(v0) ^ (total + key[total[12:11]]));
        total = total - XTEA_DELTA;
        v0    = v0 - (feistel_mix(v1) ^ (total + key[total[1:0]]));
      end
      plain_due.push_back('{first: v0, second: v1});
    endfunction

    function void check_plain(word_t p0, word_t p1);
      plain_blk_t want;
      if (plain_due.size() == 0) begin
        $error("plaintext beat %h %h arrived with nothing outstanding", p0, p1);
        failures++;
        return;
      end
      want = plain_due.pop_front();
      if (p0 !== want.first) begin
        $error("plain_first: expected %h, got %h", want.first, p0);
        failures++;
      end
      if (p1 !== want.second) begin
        $error("plain_second: expected %h, got %h", want.second, p1);
        failures++;
      end
    endfunction

    function int pending();
      return plain_due.size();
    endfunction
  endclass

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 cfg_we           = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_index        = KEY_IDX_0;
  word_t                cfg_wdata        = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  word_t                in_cipher_first  = '0;
  word_t                in_cipher_second = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  word_t                out_plain_first;
  word_t                out_plain_second;

  // When set, neither the sender nor the receiver inserts any idle cycles, so the
  // pipeline runs at full rate for a long stretch.
  bit steady = 1'b0;

  xtea_plain_tracker tracker = new();

  xtea_block_decrypt #(
    .ROUND_PAIRS(ROUND_PAIRS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cipher_first (in_cipher_first),
    .in_cipher_second(in_cipher_second),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_plain_first (out_plain_first),
    .out_plain_second(out_plain_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls with a probability of 31 percent, except during the steady
  // stretch. The decision for each cycle is made at the edge before it, so the stall
  // seen at an edge is always the value set at the previous edge.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 31);
  end

  // Every output beat that the receiver takes is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_plain(out_plain_first, out_plain_second);
    end
  end

  // Writes all four key words on back-to-back cycles. The block must be empty when this
  // runs, since a key change would otherwise hit blocks already in the pipeline.
  task automatic load_key(input key_set_t new_key);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= KEY_ORDER[i];
      cfg_wdata <= new_key[KEY_ORDER[i]];
      @(posedge clk);
      tracker.set_key(KEY_ORDER[i], new_key[KEY_ORDER[i]]);
    end
    cfg_we <= 1'b0;
  endtask

  // Presents one ciphertext block and holds it until the block takes it. Random idle
  // cycles go in front of the beat unless the run is in its steady stretch.
  task automatic send_block(input word_t c0, input word_t c1);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cipher_first  <= c0;
    in_cipher_second <= c1;
    do @(posedge clk); while (in_stall);
    tracker.note_cipher(c0, c1);
  endtask

  // Lets every outstanding block come out, then a little more so that anything the
  // block produces beyond what was predicted shows up as an unexpected beat.
  task automatic drain_pipe();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  // Random words lean toward the corners: all zeros, all ones and single set or clear
  // bits appear often, plain random words the rest of the time.
  function automatic word_t pick_word();
    int unsigned sel = $urandom_range(9);
    int unsigned bitpos = $urandom_range(31);
    case (sel)
      0: return '0;
      1: return '1;
      2: return word_t'(1) << bitpos;
      3: return ~(word_t'(1) << bitpos);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_block(pick_word(), pick_word());
    end
  endtask

  function automatic key_set_t random_key();
    key_set_t k;
    for (int i = 0; i < 4; i++) k[i] = $urandom;
    return k;
  endfunction

  initial begin
    key_set_t       reset_key;
    plain_blk_t     corner_blocks[$];
    reset_key = {KEY_RST_3, KEY_RST_2, KEY_RST_1, KEY_RST_0};
    corner_blocks = '{
      '{32'h0000_0000, 32'h0000_0000}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'h0000_0000, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'h0000_0000},
      '{32'h8000_0000, 32'h0000_0001}, '{32'h0000_0001, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'h8000_0000}, '{32'hAAAA_AAAA, 32'h5555_5555},
      '{32'h5555_5555, 32'hAAAA_AAAA}, '{32'hDEAD_BEEF, 32'h0123_4567},
      '{32'h0000_0800, 32'h0000_1000}, '{32'hFFFF_F7FF, 32'hFFFF_EFFF},
      '{32'h1234_5678, 32'h9ABC_DEF0}, '{32'h0F0F_0F0F, 32'hF0F0_F0F0}
    };

    // Synchronous reset, held at the start and then released for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The corner blocks run first with the key the block comes out of reset with,
    // before any register has been written.
    foreach (corner_blocks[i]) send_block(corner_blocks[i].first, corner_blocks[i].second);
    send_random(300);
    in_valid <= 1'b0;
    drain_pipe();

    // All-zero key: every key add degenerates to the sum alone.
    load_key('0);
    send_random(250);
    in_valid <= 1'b0;
    drain_pipe();

    // All-ones key, the other extreme, which makes every key add wrap except where the sum is zero.
    load_key('1);
    send_random(250);
    in_valid <= 1'b0;
    drain_pipe();

    // A random key and a long stretch at full rate with no gaps on either side, which
    // keeps every pipeline stage busy at once.
    load_key(random_key());
    steady = 1'b1;
    send_random(400);
    in_valid <= 1'b0;
    drain_pipe();
    steady = 1'b0;

    // Another random key with gaps and stalls back on.
    load_key(random_key());
    send_random(300);
    in_valid <= 1'b0;
    drain_pipe();

    // Writing the reset values back must give the same behavior as after reset.
    load_key(reset_key);
    foreach (corner_blocks[i]) send_block(corner_blocks[i].first, corner_blocks[i].second);
    send_random(250);
    in_valid <= 1'b0;
    drain_pipe();

    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every beat delayed by long
  // gaps and stalls.
  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
